FILE: hw/rtl/nfsd_pkg.sv
`default_nettype none

package nfsd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 10;

  localparam logic [ByteW-1:0] XorMask    = 8'h20;
  localparam logic [ByteW-1:0] ChUpperA   = 8'h41;
  localparam logic [ByteW-1:0] ChUpperZ   = 8'h5A;
  localparam logic [ByteW-1:0] ChDigit0   = 8'h30;
  localparam logic [ByteW-1:0] ChDigit9   = 8'h39;
  localparam logic [ByteW-1:0] ChDot      = 8'h2E;
  localparam logic [ByteW-1:0] ChComma    = 8'h2C;
  localparam logic [ByteW-1:0] ChColon    = 8'h3A;
  localparam logic [ByteW-1:0] ChHyphen   = 8'h2D;
  localparam logic [ByteW-1:0] ChUnder    = 8'h5F;

  localparam logic [ByteW-1:0] StartReset   = 8'd126;
  localparam logic [ByteW-1:0] EscapeReset  = 8'd125;
  localparam logic [ByteW-1:0] NameEndReset = 8'd127;

  typedef enum logic [2:0] {
    EvNone     = 3'd0,
    EvNameChar = 3'd1,
    EvNameDone = 3'd2,
    EvContent  = 3'd3,
    EvFileEnd  = 3'd4,
    EvError    = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    ErrNone      = 2'd0,
    ErrTooLong   = 2'd1,
    ErrEmptyName = 2'd2,
    ErrBadChar   = 2'd3
  } error_e;

  typedef enum logic [1:0] {
    CfgStart   = 2'd0,
    CfgEscape  = 2'd1,
    CfgNameEnd = 2'd2,
    CfgSpare   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    event_e            event_res;
    logic [ByteW-1:0]  data_byte;
    error_e            error_code;
    logic [CountW-1:0] count;
    logic              block_full;
  } out_word_t;

  typedef struct packed {
    logic [1:0]       index;
    logic [ByteW-1:0] data;
  } cfg_word_t;

  typedef struct packed {
    logic [ByteW-1:0] start_byte;
    logic [ByteW-1:0] escape_byte;
    logic [ByteW-1:0] name_end_byte;
  } markers_t;

  function automatic logic name_char_ok(input logic [ByteW-1:0] b);
    return ((b >= ChUpperA) && (b <= ChUpperZ)) ||
           ((b >= ChDigit0) && (b <= ChDigit9)) ||
           (b == ChDot) || (b == ChComma) || (b == ChColon) ||
           (b == ChHyphen) || (b == ChUnder);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/nfsd_stream_if.sv
`default_nettype none

interface nfsd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/nfsd_engine.sv
`default_nettype none

module nfsd_engine #(
  parameter int unsigned NAME_MAX   = 32,
  parameter int unsigned BLOCK_SIZE = 512
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           advance_i,
  input  wire logic [nfsd_pkg::ByteW-1:0]     rx_byte_i,
  input  wire nfsd_pkg::markers_t             markers_i,
  output nfsd_pkg::out_word_t                 result_o
);

  localparam int unsigned NameW = $clog2(NAME_MAX);
  localparam int unsigned FillW = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
  localparam logic [NameW:0] NameMaxV   = (NameW + 1)'(NAME_MAX);
  localparam logic [FillW:0] BlockSizeV = (FillW + 1)'(BLOCK_SIZE);

  logic             in_content_q, in_content_d;
  logic             esc_q, esc_d;
  logic [NameW-1:0] name_len_q, name_len_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [NameW:0]   name_inc;
  logic [FillW:0]   fill_inc;
  logic             emit;

  assign name_inc = {1'b0, name_len_q} + (NameW + 1)'(1);
  assign fill_inc = {1'b0, fill_q} + (FillW + 1)'(1);

  always_comb begin
    in_content_d = in_content_q;
    esc_d        = esc_q;
    name_len_d   = name_len_q;
    fill_d       = fill_q;
    emit         = 1'b0;
    result_o     = '{event_res:  nfsd_pkg::EvNone,
                     data_byte:  '0,
                     error_code: nfsd_pkg::ErrNone,
                     count:      '0,
                     block_full: 1'b0};

    if (!in_content_q) begin
      if (rx_byte_i == markers_i.start_byte) begin
        name_len_d = '0;
      end else if (nfsd_pkg::name_char_ok(rx_byte_i)) begin
        if (name_inc >= NameMaxV) begin
          result_o.event_res  = nfsd_pkg::EvError;
          result_o.error_code = nfsd_pkg::ErrTooLong;
          name_len_d          = '0;
        end else begin
          name_len_d         = name_inc[NameW-1:0];
          result_o.event_res = nfsd_pkg::EvNameChar;
          result_o.data_byte = rx_byte_i;
        end
      end else if (rx_byte_i == markers_i.name_end_byte) begin
        if (name_len_q == '0) begin
          result_o.event_res  = nfsd_pkg::EvError;
          result_o.error_code = nfsd_pkg::ErrEmptyName;
        end else begin
          result_o.event_res = nfsd_pkg::EvNameDone;
          result_o.count     = nfsd_pkg::CountW'(name_len_q);
          name_len_d         = '0;
          in_content_d       = 1'b1;
          fill_d             = '0;
          esc_d              = 1'b0;
        end
      end else begin
        result_o.event_res  = nfsd_pkg::EvError;
        result_o.error_code = nfsd_pkg::ErrBadChar;
      end
    end else begin
      if (esc_q) begin
        esc_d              = 1'b0;
        result_o.data_byte = rx_byte_i ^ nfsd_pkg::XorMask;
        emit               = 1'b1;
      end else if (rx_byte_i == markers_i.escape_byte) begin
        esc_d = 1'b1;
      end else if (rx_byte_i == markers_i.start_byte) begin
        result_o.event_res = nfsd_pkg::EvFileEnd;
        result_o.count     = nfsd_pkg::CountW'(fill_q);
        in_content_d       = 1'b0;
        fill_d             = '0;
        name_len_d         = '0;
      end else begin
        result_o.data_byte = rx_byte_i;
        emit               = 1'b1;
      end
      if (emit) begin
        result_o.event_res = nfsd_pkg::EvContent;
        if (fill_inc >= BlockSizeV) begin
          fill_d              = '0;
          result_o.block_full = 1'b1;
        end else begin
          fill_d = fill_inc[FillW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_content_q <= 1'b0;
      esc_q        <= 1'b0;
      name_len_q   <= '0;
      fill_q       <= '0;
    end else if (advance_i) begin
      in_content_q <= in_content_d;
      esc_q        <= esc_d;
      name_len_q   <= name_len_d;
      fill_q       <= fill_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/named_file_stream_deframer_core.sv
// Channel  Direction  Word          Fields
// rx_i     in         in_word_t     rx_byte
// res_o    out        out_word_t    event_res, data_byte, error_code, count, block_full
// cfg_i    in         cfg_word_t    index, data (always ready)
//
// One byte is accepted per cycle while res_o is not stalled; its result is registered.
// The rate is set by the combinational decode between the input and result registers.
// Reset restores the marker bytes to their defaults and returns to name mode.
// While res_o is stalled, one further byte is held in the input register.
`default_nettype none

module named_file_stream_deframer_core #(
  parameter int unsigned NAME_MAX   = 32,
  parameter int unsigned BLOCK_SIZE = 512
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  nfsd_stream_if.sink   rx_i,
  nfsd_stream_if.source res_o,
  nfsd_stream_if.sink   cfg_i
);

  logic                        in_valid_q;
  logic [nfsd_pkg::ByteW-1:0]  in_byte_q;
  logic                        out_valid_q;
  nfsd_pkg::out_word_t         out_q;
  nfsd_pkg::out_word_t         result;
  nfsd_pkg::markers_t          markers_q;
  nfsd_pkg::cfg_word_t         cfg_word;
  logic                        advance;

  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign rx_i.ready  = !in_valid_q || advance;
  assign res_o.valid = out_valid_q;
  assign res_o.payload = out_q;
  assign cfg_i.ready = 1'b1;
  assign cfg_word    = cfg_i.payload;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.valid && rx_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.payload.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      markers_q.start_byte    <= nfsd_pkg::StartReset;
      markers_q.escape_byte   <= nfsd_pkg::EscapeReset;
      markers_q.name_end_byte <= nfsd_pkg::NameEndReset;
    end else if (cfg_i.valid) begin
      unique case (nfsd_pkg::cfg_idx_e'(cfg_word.index))
        nfsd_pkg::CfgStart:   markers_q.start_byte    <= cfg_word.data;
        nfsd_pkg::CfgEscape:  markers_q.escape_byte   <= cfg_word.data;
        nfsd_pkg::CfgNameEnd: markers_q.name_end_byte <= cfg_word.data;
        default: ;
      endcase
    end
  end

  nfsd_engine #(
    .NAME_MAX   (NAME_MAX),
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .rx_byte_i (in_byte_q),
    .markers_i (markers_q),
    .result_o  (result)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/nfsd_checker.sv
`default_nettype none

module nfsd_checker (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  nfsd_stream_if.source res_o
);

  nfsd_pkg::out_word_t word;

  assign word = res_o.payload;

  // A stalled result word must hold until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |=> res_o.valid && $stable(res_o.payload))
    else $error("result word changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> ((word.error_code != nfsd_pkg::ErrNone) ==
                     (word.event_res == nfsd_pkg::EvError)))
    else $error("error code does not match the error event");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && word.block_full |-> word.event_res == nfsd_pkg::EvContent)
    else $error("block full flagged on a word that is not content");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (word.count != '0) |->
      (word.event_res == nfsd_pkg::EvNameDone) || (word.event_res == nfsd_pkg::EvFileEnd))
    else $error("count set on an event that carries none");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (word.event_res == nfsd_pkg::EvNameDone) |-> word.count != '0)
    else $error("name completed with zero length");

endmodule

bind named_file_stream_deframer_core nfsd_checker u_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .res_o  (res_o)
);

`default_nettype wire
